@@ hdl/indexed_list_engine_defines.svh @@
// ----------------------------------------------------------------------------
// indexed_list_engine_defines.svh
// Assertion macros used by the checker file of the list engine.
// ----------------------------------------------------------------------------
`ifndef INDEXED_LIST_ENGINE_DEFINES_SVH
`define INDEXED_LIST_ENGINE_DEFINES_SVH

// Implication checked at every clock edge outside reset.
`define ILE_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("indexed_list_engine: implication check failed");

// Condition that must hold at every clock edge outside reset.
`define ILE_ASSERT_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("indexed_list_engine: invariant check failed");

`endif

@@ hdl/ile_pkg.sv @@
// ----------------------------------------------------------------------------
// ile_pkg
// Constants, codes and types shared by the indexed list engine modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ile_pkg;

	localparam int CAPACITY = 64;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int FUNC_W   = 3;
	localparam int POS_W    = 12;
	localparam int DATA_W   = 32;
	localparam int LEN_W    = 13;

	localparam logic [FUNC_W-1:0] OP_READ   = 3'd0;
	localparam logic [FUNC_W-1:0] OP_HEAD   = 3'd1;
	localparam logic [FUNC_W-1:0] OP_TAIL   = 3'd2;
	localparam logic [FUNC_W-1:0] OP_AT     = 3'd3;
	localparam logic [FUNC_W-1:0] OP_DELETE = 3'd4;

	localparam logic [DATA_W-1:0] MISS_VALUE = {DATA_W{1'b1}};

	typedef enum logic [1:0] {
		SQ_READ,
		SQ_INSERT,
		SQ_DELETE
	} seq_op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD_ADDR,
		ST_RD_DATA,
		ST_FETCH,
		ST_STORE,
		ST_PLACE
	} state_t;

	typedef struct packed {
		seq_op_t            op;
		logic [IDX_W-1:0]   first;
		logic [IDX_W-1:0]   stop;
		logic               copy;
		logic [DATA_W-1:0]  value;
	} seq_cmd_t;

	typedef struct packed {
		logic    busy;
		logic    fin;
		seq_op_t op;
	} seq_stat_t;

endpackage

`default_nettype wire

@@ hdl/ile_ram.sv @@
// ----------------------------------------------------------------------------
// ile_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ile_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

@@ hdl/ile_seq.sv @@
// ----------------------------------------------------------------------------
// ile_seq
// Sequencer that walks the entry memory one word at a time: reads an entry,
// moves entries up or down by one place, and places an inserted word.
// ----------------------------------------------------------------------------
`default_nettype none

module ile_seq (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      go,
	input  wire ile_pkg::seq_cmd_t         cmd,
	input  wire logic [ile_pkg::DATA_W-1:0] rdata,
	output logic                           we,
	output logic      [ile_pkg::IDX_W-1:0] waddr,
	output logic      [ile_pkg::DATA_W-1:0] wdata,
	output logic      [ile_pkg::IDX_W-1:0] raddr,
	output ile_pkg::seq_stat_t             stat
);

	import ile_pkg::*;

	state_t            state_q;
	state_t            state_d;
	seq_op_t           op_q;
	logic [IDX_W-1:0]  idx_q;
	logic [IDX_W-1:0]  stop_q;
	logic [DATA_W-1:0] val_q;
	logic [IDX_W-1:0]  nxt;
	logic              last;

	// Shared step unit: neighbor index and end-of-walk compare.
	assign nxt  = (op_q == SQ_INSERT) ? idx_q - IDX_W'(1) : idx_q + IDX_W'(1);
	assign last = (nxt == stop_q);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (go) begin
					case (cmd.op)
						SQ_READ:   state_d = ST_RD_ADDR;
						SQ_INSERT: state_d = cmd.copy ? ST_FETCH : ST_PLACE;
						SQ_DELETE: state_d = ST_FETCH;
						default:   state_d = ST_IDLE;
					endcase
				end
			end
			ST_RD_ADDR: state_d = ST_RD_DATA;
			ST_RD_DATA: state_d = ST_IDLE;
			ST_FETCH:   state_d = ST_STORE;
			ST_STORE: begin
				if (!last) begin
					state_d = ST_FETCH;
				end else if (op_q == SQ_INSERT) begin
					state_d = ST_PLACE;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_PLACE:   state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		we        = 1'b0;
		waddr     = idx_q;
		wdata     = rdata;
		raddr     = idx_q;
		stat.busy = (state_q != ST_IDLE);
		stat.fin  = 1'b0;
		stat.op   = op_q;
		case (state_q)
			ST_RD_DATA: stat.fin = 1'b1;
			// source of a move is the neighbor of the destination
			ST_FETCH:   raddr = nxt;
			ST_STORE: begin
				we       = 1'b1;
				stat.fin = last && (op_q == SQ_DELETE);
			end
			ST_PLACE: begin
				we       = 1'b1;
				waddr    = stop_q;
				wdata    = val_q;
				stat.fin = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= SQ_READ;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE && go) begin
				op_q <= cmd.op;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && go) begin
			idx_q  <= cmd.first;
			stop_q <= cmd.stop;
			val_q  <= cmd.value;
		end else if (state_q == ST_STORE) begin
			idx_q <= nxt;
		end
	end

endmodule

`default_nettype wire

@@ hdl/indexed_list_engine.sv @@
// ----------------------------------------------------------------------------
// indexed_list_engine
// Ordered list of signed 32-bit words with read, insert and delete by
// position, kept in a single-port-pair memory plus a length register.
//
//   channel   dir  handshake            words
//   request   in   start && !busy       func, position, value
//   result    out  valid (one cycle)    read_value, done_res, full_res, length
//
// A request that needs no memory access returns its result the next cycle.
// A read passes through the address and data states before the next accept.
// A move shifts one word at a time (memory read, then write), and an insert
// then writes the new word at its position.
// Reset clears the length; memory contents are not cleared.
// The result is shown for one cycle and cannot be held off.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_list_engine (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	output logic                                   busy,
	input  wire logic        [ile_pkg::FUNC_W-1:0] func,
	input  wire logic        [ile_pkg::POS_W-1:0]  position,
	input  wire logic signed [ile_pkg::DATA_W-1:0] value,
	output logic                                   valid,
	output logic signed      [ile_pkg::DATA_W-1:0] read_value,
	output logic                                   done_res,
	output logic                                   full_res,
	output logic             [ile_pkg::LEN_W-1:0]  length
);

	import ile_pkg::*;

	logic [CNT_W-1:0]  count_q;
	logic              valid_q;
	logic [DATA_W-1:0] read_value_q;
	logic              done_q;
	logic              full_q;

	logic [LEN_W-1:0]  cnt_l;
	logic [LEN_W-1:0]  pos_l;
	logic [LEN_W-1:0]  ins_pos_l;
	logic              is_full;
	logic              rd_hit;
	logic              ins_req;
	logic              del_hit;
	logic              del_copy;
	logic              accept;
	logic              seq_go;
	logic              imm;

	seq_cmd_t          cmd;
	seq_stat_t         stat;
	logic              ram_we;
	logic [IDX_W-1:0]  ram_waddr;
	logic [DATA_W-1:0] ram_wdata;
	logic [IDX_W-1:0]  ram_raddr;
	logic [DATA_W-1:0] ram_rdata;

	assign cnt_l   = LEN_W'(count_q);
	assign pos_l   = LEN_W'(position);
	assign is_full = (count_q == CNT_W'(CAPACITY));
	assign accept  = start && !stat.busy;

	always_comb begin
		rd_hit    = 1'b0;
		ins_req   = 1'b0;
		del_hit   = 1'b0;
		ins_pos_l = '0;
		case (func)
			OP_READ:   rd_hit = (pos_l < cnt_l);
			OP_HEAD:   ins_req = 1'b1;
			OP_TAIL: begin
				ins_req   = 1'b1;
				ins_pos_l = cnt_l;
			end
			OP_AT: begin
				ins_req   = (pos_l <= cnt_l);
				ins_pos_l = pos_l;
			end
			OP_DELETE: del_hit = (pos_l < cnt_l);
			default: ;
		endcase
	end

	// Deleting the last entry moves nothing: finish it at once.
	assign del_copy = del_hit && ((pos_l + LEN_W'(1)) < cnt_l);
	assign seq_go   = accept && (rd_hit || (ins_req && !is_full) || del_copy);
	assign imm      = accept && !seq_go;

	always_comb begin
		cmd.value = value;
		cmd.copy  = (ins_pos_l < cnt_l);
		if (rd_hit) begin
			cmd.op    = SQ_READ;
			cmd.first = IDX_W'(pos_l);
			cmd.stop  = IDX_W'(pos_l);
		end else if (ins_req) begin
			cmd.op    = SQ_INSERT;
			cmd.first = IDX_W'(cnt_l);
			cmd.stop  = IDX_W'(ins_pos_l);
		end else begin
			cmd.op    = SQ_DELETE;
			cmd.first = IDX_W'(pos_l);
			cmd.stop  = IDX_W'(cnt_l - LEN_W'(1));
		end
	end

	ile_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (seq_go),
		.cmd    (cmd),
		.rdata  (ram_rdata),
		.we     (ram_we),
		.waddr  (ram_waddr),
		.wdata  (ram_wdata),
		.raddr  (ram_raddr),
		.stat   (stat)
	);

	ile_ram #(
		.WIDTH (DATA_W),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			count_q <= '0;
		end else begin
			valid_q <= imm || stat.fin;
			if (imm && del_hit) begin
				count_q <= count_q - CNT_W'(1);
			end else if (stat.fin) begin
				case (stat.op)
					SQ_INSERT: count_q <= count_q + CNT_W'(1);
					SQ_DELETE: count_q <= count_q - CNT_W'(1);
					default:   count_q <= count_q;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (imm) begin
			read_value_q <= MISS_VALUE;
			done_q       <= del_hit;
			full_q       <= ins_req && is_full;
		end else if (stat.fin) begin
			read_value_q <= (stat.op == SQ_READ) ? ram_rdata : MISS_VALUE;
			done_q       <= 1'b1;
			full_q       <= 1'b0;
		end
	end

	assign busy       = stat.busy;
	assign valid      = valid_q;
	assign read_value = read_value_q;
	assign done_res   = done_q;
	assign full_res   = full_q;
	assign length     = LEN_W'(count_q);

endmodule

`default_nettype wire

@@ hdl/ile_checker.sv @@
// ----------------------------------------------------------------------------
// ile_checker
// Port-level checks on the list engine's results, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "indexed_list_engine_defines.svh"

module ile_checker (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              busy,
	input wire logic                              valid,
	input wire logic signed [ile_pkg::DATA_W-1:0] read_value,
	input wire logic                              done_res,
	input wire logic                              full_res,
	input wire logic        [ile_pkg::LEN_W-1:0]  length
);

	import ile_pkg::*;

	// a refused insert only happens at capacity
	`ILE_ASSERT_IMP(a_full_len, valid && full_res, length == LEN_W'(CAPACITY))
	// a result without done shows the miss word
	`ILE_ASSERT_IMP(a_miss_val, valid && !done_res, read_value == MISS_VALUE)
	// a result is only shown once the sequencer is free again
	`ILE_ASSERT_IMP(a_idle_res, valid, !busy)
	// the length moves only together with a result
	`ILE_ASSERT_IMP(a_len_move, length != $past(length), valid)
	`ILE_ASSERT_ALWAYS(a_len_cap, length <= LEN_W'(CAPACITY))

endmodule

bind indexed_list_engine ile_checker u_ile_checker (.*);

`default_nettype wire
